FILE: rtl/core/schroeder_allpass_delay_defines.svh
// Assertion macros for the Schroeder allpass delay block.
// Clocked on aclk, disabled while aresetn is low; no other dependencies.
`ifndef SCHROEDER_ALLPASS_DELAY_DEFINES_SVH
`define SCHROEDER_ALLPASS_DELAY_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication
`define SAP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("allpass delay: same-cycle check failed");

// Next-cycle implication
`define SAP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("allpass delay: next-cycle check failed");

`else

`define SAP_ASSERT_IMP(lbl, ante, cons)
`define SAP_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

FILE: rtl/core/sap_pkg.sv
// Shared types, constants and helpers for the Schroeder allpass delay block.
// No dependencies.
package sap_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int LEN_W         = 12;
    localparam int IDX_W         = 2;
    localparam int CNT_W         = $clog2(SAMPLE_W);
    localparam int PH_W          = SAMPLE_W + 2;
    localparam int ACC_W         = SAMPLE_W + 4;
    localparam int DEPTH_DEFAULT = 4096;

    localparam logic [LEN_W-1:0]           LEN_RESET  = LEN_W'(1);
    localparam logic signed [SAMPLE_W-1:0] GAIN_RESET = 16'sd16384;

    localparam logic [IDX_W-1:0] REG_DELAY_LENGTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_FEEDBACK_GAIN = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_ADDR,
        ST_READ,
        ST_MUL1,
        ST_FEED,
        ST_MUL2,
        ST_FIN
    } sap_state_t;

    // Clamp a wide signed sum into the Q1.15 range
    function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [ACC_W-1:0] x);
        logic signed [ACC_W-1:0] hi_lim;
        logic signed [ACC_W-1:0] lo_lim;
        hi_lim = ACC_W'(32767);
        lo_lim = -ACC_W'(32768);
        if (x > hi_lim) begin
            return 16'sh7fff;
        end else if (x < lo_lim) begin
            return 16'sh8000;
        end
        return x[SAMPLE_W-1:0];
    endfunction

endpackage

FILE: rtl/core/schroeder_allpass_delay.sv
// Schroeder allpass section on a circular delay memory, single module.
// Depends on sap_pkg and schroeder_allpass_delay_defines.svh.
//
// One word in, one word out. After accepting a word the block reduces
// delay_length modulo DELAY_DEPTH in a restoring compare-subtract unit,
// forms the read address and reads the delay memory, runs a bit-serial
// 16x16 multiplier twice (d*gain, then feed*gain) with a feed step between,
// and loads the result; only then is the next word accepted, and the load
// waits while an earlier result is untaken. The result sits in an output
// register, so the next word is accepted while it waits. Memory entries not
// yet written since reset read as zero through a fill count, so there is no
// clearing pass after reset. Configuration is written through
// cfg_we/cfg_index/cfg_wdata while idle: a user rule the block does not enforce.
module schroeder_allpass_delay
    import sap_pkg::*;
#(
    parameter int DELAY_DEPTH = DEPTH_DEFAULT
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [IDX_W-1:0]           cfg_index,
    input  logic [SAMPLE_W-1:0]        cfg_wdata,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [SAMPLE_W-1:0] s_sample_in,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [SAMPLE_W-1:0] m_sample_out
);

`include "schroeder_allpass_delay_defines.svh"

    localparam int AW     = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
    localparam int FILL_W = AW + 1;
    localparam int DW     = ((AW > LEN_W) ? AW : LEN_W) + 1;
    localparam int CW     = LEN_W + AW + 1;

    sap_state_t state_reg, state_next;

    logic [LEN_W-1:0]           dlen_reg;
    logic signed [SAMPLE_W-1:0] gain_reg;
    logic [AW-1:0]              wp_reg;
    logic [FILL_W-1:0]          fill_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic [LEN_W-1:0]           rem_reg;
    logic [AW-1:0]              rd_addr_reg;
    logic                       hit_reg;
    logic [SAMPLE_W-1:0]        mem_q_reg;
    logic signed [SAMPLE_W-1:0] s_reg;
    logic signed [SAMPLE_W-1:0] v_reg;
    logic [SAMPLE_W-1:0]        b_sh_reg;
    logic signed [SAMPLE_W:0]   hi_reg;
    logic [SAMPLE_W-1:0]        lo_reg;
    logic                       m_valid_reg;
    logic signed [SAMPLE_W-1:0] m_out_reg;

    logic [SAMPLE_W-1:0] mem [DELAY_DEPTH];

    logic                       accept;
    logic                       out_load;
    logic                       mul_last;
    logic [CW-1:0]              mod_shifted;
    logic                       mod_ge;
    logic [DW-1:0]              diff;
    logic [DW-1:0]              rd_wide;
    logic signed [SAMPLE_W-1:0] d_val;
    logic signed [SAMPLE_W-1:0] mcand;
    logic signed [PH_W-1:0]     addend;
    logic signed [PH_W-1:0]     mul_sum;
    logic signed [PH_W-1:0]     prod_hi;
    logic signed [ACC_W-1:0]    v_acc;
    logic signed [ACC_W-1:0]    y_acc;
    logic signed [SAMPLE_W-1:0] v_sat;
    logic signed [SAMPLE_W-1:0] y_sat;

    // Handshake and controls
    assign s_ready      = (state_reg == ST_IDLE);
    assign accept       = s_valid && s_ready;
    assign m_valid      = m_valid_reg;
    assign m_sample_out = m_out_reg;
    assign mul_last     = (cnt_reg == CNT_W'(SAMPLE_W - 1));
    assign out_load     = (state_reg == ST_FIN) && (!m_valid_reg || m_ready);

    // Restoring reduction step: compare against depth shifted by the bit count
    assign mod_shifted = CW'(DELAY_DEPTH) << cnt_reg;
    assign mod_ge      = (CW'(rem_reg) >= mod_shifted);

    // Read address: write pointer minus reduced delay, wrapped into the memory
    assign diff    = DW'(wp_reg) - DW'(rem_reg);
    assign rd_wide = diff[DW-1] ? (diff + DW'(DELAY_DEPTH)) : diff;

    // Delayed value; entries not yet written read as zero
    assign d_val = hit_reg ? $signed(mem_q_reg) : '0;

    // Bit-serial multiplier: add or, on the sign bit, subtract the multiplicand
    assign mcand   = (state_reg == ST_MUL1) ? d_val : v_reg;
    assign addend  = !b_sh_reg[0] ? '0 :
                     mul_last ? -{{2{mcand[SAMPLE_W-1]}}, mcand}
                              :  {{2{mcand[SAMPLE_W-1]}}, mcand};
    assign mul_sum = {hi_reg[SAMPLE_W], hi_reg} + addend;
    assign prod_hi = {hi_reg, lo_reg[SAMPLE_W-1]};

    // Feed value: s - round(d*g), result: d + round(v*g), both saturated
    assign v_acc = {{4{s_reg[SAMPLE_W-1]}}, s_reg}
                 - {{2{prod_hi[PH_W-1]}}, prod_hi}
                 - ACC_W'(lo_reg[14] && (lo_reg[13:0] != '0));
    assign y_acc = {{4{d_val[SAMPLE_W-1]}}, d_val}
                 + {{2{prod_hi[PH_W-1]}}, prod_hi}
                 + ACC_W'(lo_reg[14]);
    assign v_sat = sat16(v_acc);
    assign y_sat = sat16(y_acc);

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_MOD;
            end
            ST_MOD: begin
                if (cnt_reg == '0) state_next = ST_ADDR;
            end
            ST_ADDR: state_next = ST_READ;
            ST_READ: state_next = ST_MUL1;
            ST_MUL1: begin
                if (mul_last) state_next = ST_FEED;
            end
            ST_FEED: state_next = ST_MUL2;
            ST_MUL2: begin
                if (mul_last) state_next = ST_FIN;
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Configuration, pointer, fill count and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dlen_reg    <= LEN_RESET;
            gain_reg    <= GAIN_RESET;
            wp_reg      <= '0;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we && (cfg_index == REG_DELAY_LENGTH)) begin
                dlen_reg <= cfg_wdata[LEN_W-1:0];
            end
            if (cfg_we && (cfg_index == REG_FEEDBACK_GAIN)) begin
                gain_reg <= $signed(cfg_wdata);
            end
            // Advance the pointer and count filled entries on each memory write
            if (state_reg == ST_FEED) begin
                wp_reg <= (wp_reg == AW'(DELAY_DEPTH - 1)) ? '0 : wp_reg + AW'(1);
                if (fill_reg != FILL_W'(DELAY_DEPTH)) begin
                    fill_reg <= fill_reg + FILL_W'(1);
                end
            end
            // Hold the result word until taken
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            s_reg   <= s_sample_in;
            rem_reg <= dlen_reg;
            cnt_reg <= CNT_W'(LEN_W - 1);
        end
        case (state_reg)
            ST_MOD: begin
                if (mod_ge) rem_reg <= rem_reg - mod_shifted[LEN_W-1:0];
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
            ST_ADDR: begin
                rd_addr_reg <= rd_wide[AW-1:0];
            end
            ST_READ: begin
                hit_reg  <= (FILL_W'(rd_addr_reg) < fill_reg);
                b_sh_reg <= gain_reg;
                hi_reg   <= '0;
                lo_reg   <= '0;
                cnt_reg  <= '0;
            end
            ST_MUL1, ST_MUL2: begin
                hi_reg   <= mul_sum[PH_W-1:1];
                lo_reg   <= {mul_sum[0], lo_reg[SAMPLE_W-1:1]};
                b_sh_reg <= {1'b0, b_sh_reg[SAMPLE_W-1:1]};
                cnt_reg  <= cnt_reg + CNT_W'(1);
            end
            ST_FEED: begin
                v_reg    <= v_sat;
                b_sh_reg <= gain_reg;
                hi_reg   <= '0;
                lo_reg   <= '0;
                cnt_reg  <= '0;
            end
            default: begin
            end
        endcase
        if (out_load) begin
            m_out_reg <= y_sat;
        end
    end

    // Delay memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (state_reg == ST_FEED) begin
            mem[wp_reg] <= v_sat;
        end
        if (state_reg == ST_READ) begin
            mem_q_reg <= mem[rd_addr_reg];
        end
    end

    // Checks
    `SAP_ASSERT_NXT(a_accept_busy, accept, state_reg == ST_MOD)
    `SAP_ASSERT_IMP(a_rem_reduced, state_reg == ST_ADDR, CW'(rem_reg) < CW'(DELAY_DEPTH))
    `SAP_ASSERT_IMP(a_fill_bound, 1'b1, fill_reg <= FILL_W'(DELAY_DEPTH))
    `SAP_ASSERT_IMP(a_wp_bound, 1'b1, FILL_W'(wp_reg) < FILL_W'(DELAY_DEPTH))
    `SAP_ASSERT_NXT(a_mul_runs, (state_reg == ST_MUL1) && !mul_last, state_reg == ST_MUL1)

endmodule
